/* src/tds_pkg.sv */
// ----------------------------------------------------------------------------
// tds_pkg
// Shared widths, codes and types of the timer divider search unit.
// ----------------------------------------------------------------------------
package tds_pkg;

	// field widths
	localparam int CLK_W  = 30;
	localparam int FREQ_W = 24;
	localparam int PRE_W  = 10;
	localparam int RLD_W  = 16;

	// table length is a power of two, so the rate scaling is a shift
	localparam int TABLE_LENGTH = 128;
	localparam int TABLE_SHIFT  = $clog2(TABLE_LENGTH);
	localparam int TGT_W        = FREQ_W + TABLE_SHIFT;

	// search range
	localparam int PRESCALER_LIMIT = 1024;
	localparam int PDIV_W          = $clog2(PRESCALER_LIMIT) + 1;
	localparam int MAX_PERIOD      = 65536;
	localparam int PER_W           = $clog2(MAX_PERIOD) + 1;
	localparam int PROD_W          = PDIV_W + PER_W;

	// bit-serial divider
	localparam int DIV_STEPS = CLK_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(84000000);

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_ZERO   = 2'd1,
		STAT_NOPAIR = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_IDEAL,
		ST_START_PER,
		ST_PERIOD,
		ST_MUL,
		ST_START_RATE,
		ST_RATE,
		ST_FINISH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [CLK_W-1:0] dividend;
		logic [TGT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [CLK_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic [PRE_W-1:0] prescaler;
		logic [RLD_W-1:0] reload;
		logic [CLK_W-1:0] achieved;
		status_t          status;
	} res_t;

endpackage

/* src/tds_divider.sv */
// ----------------------------------------------------------------------------
// tds_divider
// Restoring divider, one quotient bit per cycle, shared by all searches.
// ----------------------------------------------------------------------------
module tds_divider
	import tds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CLK_W-1:0]     dvd_q;
	logic [TGT_W-1:0]     dsr_q;
	logic [TGT_W-1:0]     rem_q;

	logic [TGT_W:0]       shift_w;
	logic [TGT_W:0]       diff_w;
	logic                 take_w;

	// trial subtraction of the divisor from the shifted remainder
	assign shift_w = {rem_q, dvd_q[CLK_W-1]};
	assign diff_w  = shift_w - {1'b0, dsr_q};
	assign take_w  = (shift_w >= {1'b0, dsr_q});

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and dividend/quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take_w ? diff_w[TGT_W-1:0] : shift_w[TGT_W-1:0];
			dvd_q <= {dvd_q[CLK_W-2:0], take_w};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

/* src/tds_ctrl.sv */
// ----------------------------------------------------------------------------
// tds_ctrl
// Search sequencer: walks the prescalers and keeps the best divider pair.
// ----------------------------------------------------------------------------
module tds_ctrl
	import tds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CLK_W-1:0]  clk_hz,
	input  logic              freq_valid,
	output logic              freq_ready,
	input  logic [FREQ_W-1:0] signal_frequency,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res,
	output div_req_t          div_req,
	input  div_rsp_t          div_rsp
);

	state_t state_q, state_d;

	logic [TGT_W-1:0]  target_q;
	logic [CLK_W-1:0]  ideal_q;
	logic [PRE_W-1:0]  p_q;
	logic [PER_W-1:0]  period_q;
	logic [PROD_W-1:0] prod_q;
	logic              found_q;
	logic [PRE_W-1:0]  best_p_q;
	logic [RLD_W-1:0]  best_r_q;
	logic [TGT_W-1:0]  best_err_q;
	logic [CLK_W-1:0]  best_rate_q;
	res_t              res_q;

	logic              accept_w;
	logic              zero_w;
	logic              last_w;
	logic              per_bad_w;
	logic [PDIV_W-1:0] pdiv_w;
	logic [TGT_W-1:0]  rate_w;
	logic [TGT_W-1:0]  err_w;
	logic              better_w;
	logic [PER_W-1:0]  reload_w;

	// per-candidate arithmetic
	assign accept_w  = freq_valid && freq_ready;
	assign zero_w    = (signal_frequency == '0);
	assign last_w    = (p_q == PRE_W'(PRESCALER_LIMIT - 1));
	assign pdiv_w    = PDIV_W'(p_q) + PDIV_W'(1);
	assign per_bad_w = (div_rsp.quotient == '0)
		|| (div_rsp.quotient > CLK_W'(MAX_PERIOD));
	assign rate_w    = TGT_W'(div_rsp.quotient);
	assign err_w     = (target_q > rate_w) ? (target_q - rate_w) : (rate_w - target_q);
	assign better_w  = !found_q || (err_w < best_err_q);
	assign reload_w  = period_q - PER_W'(1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and divider requests
	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = clk_hz;
		div_req.divisor  = target_q;
		freq_ready       = (state_q == ST_IDLE);
		res_valid        = (state_q == ST_DONE);
		unique case (state_q)
			ST_IDLE: begin
				if (freq_valid) begin
					if (zero_w) begin
						state_d = ST_DONE;
					end else begin
						div_req.start   = 1'b1;
						div_req.divisor = {signal_frequency, TABLE_SHIFT'(0)};
						state_d         = ST_IDEAL;
					end
				end
			end
			ST_IDEAL: begin
				if (div_rsp.done) begin
					state_d = ST_START_PER;
				end
			end
			ST_START_PER: begin
				div_req.start    = 1'b1;
				div_req.dividend = ideal_q;
				div_req.divisor  = TGT_W'(pdiv_w);
				state_d          = ST_PERIOD;
			end
			ST_PERIOD: begin
				if (div_rsp.done) begin
					if (!per_bad_w) begin
						state_d = ST_MUL;
					end else if (last_w) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_START_PER;
					end
				end
			end
			ST_MUL: begin
				state_d = ST_START_RATE;
			end
			ST_START_RATE: begin
				div_req.start   = 1'b1;
				div_req.divisor = TGT_W'(prod_q);
				state_d         = ST_RATE;
			end
			ST_RATE: begin
				if (div_rsp.done) begin
					if ((err_w == '0) || last_w) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_START_PER;
					end
				end
			end
			ST_FINISH: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// search datapath
	always_ff @(posedge clk) begin
		if (accept_w) begin
			target_q    <= {signal_frequency, TABLE_SHIFT'(0)};
			found_q     <= 1'b0;
			best_p_q    <= '0;
			best_r_q    <= '0;
			best_err_q  <= '0;
			best_rate_q <= '0;
			if (zero_w) begin
				res_q.prescaler <= '0;
				res_q.reload    <= '0;
				res_q.achieved  <= '0;
				res_q.status    <= STAT_ZERO;
			end
		end

		if ((state_q == ST_IDEAL) && div_rsp.done) begin
			ideal_q <= div_rsp.quotient;
			p_q     <= '0;
		end

		if ((state_q == ST_PERIOD) && div_rsp.done) begin
			period_q <= div_rsp.quotient[PER_W-1:0];
			if (per_bad_w && !last_w) begin
				p_q <= p_q + PRE_W'(1);
			end
		end

		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(pdiv_w) * PROD_W'(period_q);
		end

		// keep the first pair with the least error
		if ((state_q == ST_RATE) && div_rsp.done) begin
			if (better_w) begin
				found_q     <= 1'b1;
				best_err_q  <= err_w;
				best_p_q    <= p_q;
				best_r_q    <= reload_w[RLD_W-1:0];
				best_rate_q <= div_rsp.quotient;
			end
			if ((err_w != '0) && !last_w) begin
				p_q <= p_q + PRE_W'(1);
			end
		end

		if (state_q == ST_FINISH) begin
			res_q.prescaler <= best_p_q;
			res_q.reload    <= best_r_q;
			res_q.achieved  <= found_q ? (best_rate_q >> TABLE_SHIFT) : (clk_hz >> TABLE_SHIFT);
			res_q.status    <= found_q ? STAT_OK : STAT_NOPAIR;
		end
	end

	assign res = res_q;

endmodule

/* src/timer_divider_search_unit.sv */
// a zero frequency goes straight to the result; otherwise the ideal divisor comes
// first, then the divisions for each prescaler tried
// one request in flight at a time; the shared bit-serial divider works one bit a cycle,
// and the next request is taken while a result waits at the output
// reset: control state cleared, timer clock register set to 84000000 hz
// ----------------------------------------------------------------------------
// timer_divider_search_unit
// Picks a timer prescaler and auto-reload pair for a wanted signal frequency.
// ----------------------------------------------------------------------------
module timer_divider_search_unit
	import tds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CLK_W-1:0]  timer_clock_hz,
	input  logic              freq_valid,
	output logic              freq_ready,
	input  logic [FREQ_W-1:0] signal_frequency,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [PRE_W-1:0]  prescaler,
	output logic [RLD_W-1:0]  reload,
	output logic [CLK_W-1:0]  achieved_frequency,
	output logic [1:0]        status
);

	logic [CLK_W-1:0] clk_hz_q;
	logic             out_valid_q;
	res_t             out_q;

	logic             res_valid_w;
	logic             res_ready_w;
	res_t             res_w;
	div_req_t         div_req_w;
	div_rsp_t         div_rsp_w;

	// timer clock register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			clk_hz_q <= timer_clock_hz;
		end
	end

	// shared divider
	tds_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_w),
		.rsp    (div_rsp_w)
	);

	// search sequencer
	tds_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.clk_hz           (clk_hz_q),
		.freq_valid       (freq_valid),
		.freq_ready       (freq_ready),
		.signal_frequency (signal_frequency),
		.res_valid        (res_valid_w),
		.res_ready        (res_ready_w),
		.res              (res_w),
		.div_req          (div_req_w),
		.div_rsp          (div_rsp_w)
	);

	// output register
	assign res_ready_w = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid_w && res_ready_w) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid_w && res_ready_w) begin
			out_q <= res_w;
		end
	end

	assign result_valid       = out_valid_q;
	assign prescaler          = out_q.prescaler;
	assign reload             = out_q.reload;
	assign achieved_frequency = out_q.achieved;
	assign status             = out_q.status;

endmodule
